[sv/ppp_pkg.sv]
package ppp_pkg;

    localparam int WordW      = 32;
    localparam int FracBits   = 16;
    localparam int WordWidth  = 32;
    localparam int StoreDepth = 21;
    localparam int IdxW       = 5;
    localparam int KBase      = 0;
    localparam int RBase      = 9;
    localparam int TBase      = 18;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROJECT = 1'b1
    } t_op;

endpackage

[sv/ppp_if.sv]
interface ppp_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [4:0]  coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source (output valid, operation, coef_index, coef_value,
                    point_x, point_y, point_z, input ready);
    modport sink   (input valid, operation, coef_index, coef_value,
                    point_x, point_y, point_z, output ready);
endinterface

interface ppp_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic        depth_zero;
    logic        saturated;
    modport source (output valid, pixel_u, pixel_v, depth_zero, saturated,
                    input ready);
    modport sink   (input valid, pixel_u, pixel_v, depth_zero, saturated,
                    output ready);
endinterface

[sv/pinhole_point_projection.sv]
// Channel | Dir | Contents
// i_in    | in  | operation, coef_index, coef_value, point_x/y/z
// o_out   | out | pixel_u, pixel_v, depth_zero, saturated
//
// One item per cycle sustained while the output register is empty or taken.
// The depth is set by the bit-per-stage divider after two multiply-add stages.
// Reset clears the coefficient store and all valid bits.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Load items write rotation words on acceptance, translation words one stage
// later and intrinsic words two stages later, so earlier points keep the old
// camera; loads produce no result.
module pinhole_point_projection #(
    parameter int FRAC_BITS  = ppp_pkg::FracBits,
    parameter int WORD_WIDTH = ppp_pkg::WordWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppp_in_if.sink    i_in,
    ppp_out_if.source o_out
);
    import ppp_pkg::*;

    localparam int W    = WORD_WIDTH;
    localparam int DLAT = W + FRAC_BITS + 1;
    localparam int LAT  = 6 + DLAT;

    logic signed [WordW-1:0] r_coef [StoreDepth];
    logic w_adv;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    logic                    w_ld;
    logic [1:0]              r_ld_vld;
    logic [IdxW-1:0]         r_ld_idx [2];
    logic signed [WordW-1:0] r_ld_val [2];

    // Advance when the last stage is free or being taken
    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    assign w_ld = i_in.valid && i_in.ready && i_in.operation == OP_LOAD
                  && i_in.coef_index < IdxW'(StoreDepth);

    // Delay load words so they land behind the points already in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ld_vld <= '0;
        else if (w_adv) r_ld_vld <= {r_ld_vld[0], w_ld};
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ld_idx[0] <= i_in.coef_index;
            r_ld_idx[1] <= r_ld_idx[0];
            r_ld_val[0] <= i_in.coef_value;
            r_ld_val[1] <= r_ld_val[0];
        end
    end

    // Load coefficient words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < StoreDepth; k++) r_coef[k] <= '0;
        end else begin
            if (w_ld && i_in.coef_index >= IdxW'(RBase)
                && i_in.coef_index < IdxW'(TBase)) begin
                r_coef[i_in.coef_index] <= i_in.coef_value;
            end
            if (w_adv && r_ld_vld[0] && r_ld_idx[0] >= IdxW'(TBase)) begin
                r_coef[r_ld_idx[0]] <= r_ld_val[0];
            end
            if (w_adv && r_ld_vld[1] && r_ld_idx[1] < IdxW'(RBase)) begin
                r_coef[r_ld_idx[1]] <= r_ld_val[1];
            end
        end
    end

    // Valid chain
    assign n_vld = {r_vld[LAT-2:0],
                    i_in.valid && i_in.operation == OP_PROJECT};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_adv) r_vld <= n_vld;
    end

    // Stage 0: widen the point to the working word
    logic signed [W-1:0] r_p [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0] <= W'(i_in.point_x);
            r_p[1] <= W'(i_in.point_y);
            r_p[2] <= W'(i_in.point_z);
        end
    end

    function automatic logic signed [W-1:0] f_cw(input logic signed [WordW-1:0] c);
        return W'(c);
    endfunction

    // R*p products
    logic signed [W-1:0] w_rp [9];
    logic                w_rs [9];
    for (genvar i = 0; i < 9; i++) begin : g_rmul
        ppp_mul #(.W(W), .FRAC(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_cw(r_coef[RBase + i])), .i_b(r_p[i % 3]),
            .o_p(w_rp[i]), .o_sat(w_rs[i])
        );
    end

    // c = R*p + T, clamped
    localparam int SW = W + 3;
    localparam logic signed [SW-1:0] SumMax = {{4{1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SumMin = {{4{1'b1}}, {(W-1){1'b0}}};
    logic signed [W-1:0] r_c [3];
    logic                r_sat_c;
    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] s;
        logic                 sat;
        if (w_adv) begin
            sat = w_rs[0] | w_rs[1] | w_rs[2] | w_rs[3] | w_rs[4] |
                  w_rs[5] | w_rs[6] | w_rs[7] | w_rs[8];
            for (int i = 0; i < 3; i++) begin
                s = SW'(f_cw(r_coef[TBase + i])) + SW'(w_rp[3*i]) +
                    SW'(w_rp[3*i+1]) + SW'(w_rp[3*i+2]);
                if (s > SumMax) begin
                    sat = 1'b1; r_c[i] <= {1'b0, {(W-1){1'b1}}};
                end else if (s < SumMin) begin
                    sat = 1'b1; r_c[i] <= {1'b1, {(W-1){1'b0}}};
                end else begin
                    r_c[i] <= s[W-1:0];
                end
            end
            r_sat_c <= sat;
        end
    end

    // K*c products
    logic signed [W-1:0] w_kp [9];
    logic                w_ks [9];
    logic                r_sat_c2;
    for (genvar i = 0; i < 9; i++) begin : g_kmul
        ppp_mul #(.W(W), .FRAC(FRAC_BITS)) u_mul (
            .i_clk(i_clk), .i_en(w_adv),
            .i_a(f_cw(r_coef[KBase + i])), .i_b(r_c[i % 3]),
            .o_p(w_kp[i]), .o_sat(w_ks[i])
        );
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_sat_c2 <= r_sat_c;
    end

    // h = K*c, clamped
    logic signed [W-1:0] r_h [3];
    logic                r_sat_h;
    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] s;
        logic                 sat;
        if (w_adv) begin
            sat = r_sat_c2 | w_ks[0] | w_ks[1] | w_ks[2] | w_ks[3] | w_ks[4] |
                  w_ks[5] | w_ks[6] | w_ks[7] | w_ks[8];
            for (int i = 0; i < 3; i++) begin
                s = SW'(w_kp[3*i]) + SW'(w_kp[3*i+1]) + SW'(w_kp[3*i+2]);
                if (s > SumMax) begin
                    sat = 1'b1; r_h[i] <= {1'b0, {(W-1){1'b1}}};
                end else if (s < SumMin) begin
                    sat = 1'b1; r_h[i] <= {1'b1, {(W-1){1'b0}}};
                end else begin
                    r_h[i] <= s[W-1:0];
                end
            end
            r_sat_h <= sat;
        end
    end

    // Divide; zero divisor substitutes one and is masked later
    logic signed [W-1:0] w_d;
    logic signed [W-1:0] w_u;
    logic signed [W-1:0] w_v;
    logic                w_su;
    logic                w_sv;
    assign w_d = (r_h[2] == '0) ? W'(1) : r_h[2];

    ppp_div #(.W(W), .FRAC(FRAC_BITS)) u_div_u (
        .i_clk(i_clk), .i_en(w_adv), .i_n(r_h[0]), .i_d(w_d),
        .o_q(w_u), .o_sat(w_su)
    );
    ppp_div #(.W(W), .FRAC(FRAC_BITS)) u_div_v (
        .i_clk(i_clk), .i_en(w_adv), .i_n(r_h[1]), .i_d(w_d),
        .o_q(w_v), .o_sat(w_sv)
    );

    // Carry the flags alongside the divider
    logic [DLAT-1:0] r_dz;
    logic [DLAT-1:0] r_sf;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dz <= {r_dz[DLAT-2:0], r_h[2] == '0};
            r_sf <= {r_sf[DLAT-2:0], r_sat_h};
        end
    end

    // Output register
    logic signed [31:0] r_u;
    logic signed [31:0] r_v;
    logic               r_dzo;
    logic               r_so;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dzo <= r_dz[DLAT-1];
            r_u   <= r_dz[DLAT-1] ? '0 : 32'(w_u);
            r_v   <= r_dz[DLAT-1] ? '0 : 32'(w_v);
            r_so  <= r_sf[DLAT-1] | (!r_dz[DLAT-1] & (w_su | w_sv));
        end
    end

    assign o_out.valid      = r_vld[LAT-1];
    assign o_out.pixel_u    = r_u;
    assign o_out.pixel_v    = r_v;
    assign o_out.depth_zero = r_dzo;
    assign o_out.saturated  = r_so;

    // A zero divisor always gives zero coordinates
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.depth_zero |-> o_out.pixel_u == 0 && o_out.pixel_v == 0)
        else $error("depth_zero with nonzero output");
    // A stalled pipeline holds its output
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.pixel_u))
        else $error("output changed while stalled");
    // Input is refused only while a result waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("ready low without pending result");
endmodule

[sv/ppp_mul.sv]
// Fixed-point multiply: (a*b) >> FRAC truncated toward zero, saturated to W bits.
// One register stage after the product, then the shift and clamp.
module ppp_mul #(
    parameter int W    = ppp_pkg::WordWidth,
    parameter int FRAC = ppp_pkg::FracBits
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_p,
    output logic                o_sat
);
    import ppp_pkg::*;

    localparam int PW = 2 * W;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] w_adj;
    logic signed [PW-1:0] w_shift;
    logic signed [PW-1:0] w_max;
    logic signed [PW-1:0] w_min;

    // Form the full product
    assign n_prod = PW'(i_a) * PW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // Round toward zero: bias negatives before the arithmetic shift
    assign w_adj   = r_prod[PW-1] ? (r_prod + PW'((64'd1 << FRAC) - 64'd1)) : r_prod;
    assign w_shift = w_adj >>> FRAC;
    assign w_max   = PW'({1'b0, {(W-1){1'b1}}});
    assign w_min   = -w_max - PW'(1);

    // Clamp to the word range
    always_comb begin
        o_sat = 1'b0;
        o_p   = w_shift[W-1:0];
        if (w_shift > w_max) begin
            o_sat = 1'b1;
            o_p   = w_max[W-1:0];
        end else if (w_shift < w_min) begin
            o_sat = 1'b1;
            o_p   = w_min[W-1:0];
        end
    end
endmodule

[sv/ppp_div.sv]
// Pipelined restoring divider: (n << FRAC) / d truncated toward zero,
// saturated to W bits. One quotient bit per stage; flags travel alongside.
module ppp_div #(
    parameter int W    = ppp_pkg::WordWidth,
    parameter int FRAC = ppp_pkg::FracBits
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_n,
    input  logic signed [W-1:0] i_d,
    output logic signed [W-1:0] o_q,
    output logic                o_sat
);
    import ppp_pkg::*;

    // Dividend |n| << FRAC has W+FRAC bits; one stage per quotient bit
    localparam int NW = W + FRAC;
    localparam int DW = W + 1;

    logic [NW-1:0] r_num [NW+1];
    logic [DW-1:0] r_rem [NW+1];
    logic [NW-1:0] r_quo [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic          r_neg [NW+1];
    logic [W-1:0]  w_nmag;

    // Magnitude of the numerator; the most negative word maps to 2^(W-1)
    assign w_nmag = i_n[W-1] ? W'(-i_n) : W'(i_n);

    // Stage zero: magnitudes and sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_n[W-1] ^ i_d[W-1];
            r_num[0] <= {w_nmag, {FRAC{1'b0}}};
            r_den[0] <= i_d[W-1] ? DW'(-(DW'(i_d))) : DW'(i_d);
            r_rem[0] <= '0;
            r_quo[0] <= '0;
        end
    end

    // One restoring step per stage, numerator bits from the top
    for (genvar s = 0; s < NW; s++) begin : g_step
        logic [DW:0] w_trial;
        assign w_trial = {r_rem[s], r_num[s][NW-1]} - {1'b0, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= r_num[s] << 1;
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                if (!w_trial[DW]) begin
                    r_rem[s+1] <= w_trial[DW-1:0];
                    r_quo[s+1] <= {r_quo[s][NW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= DW'({r_rem[s], r_num[s][NW-1]});
                    r_quo[s+1] <= {r_quo[s][NW-2:0], 1'b0};
                end
            end
        end
    end

    // Apply sign and clamp
    logic [NW-1:0] w_q;
    logic [NW-1:0] w_lim;
    assign w_q   = r_quo[NW];
    assign w_lim = NW'(1) << (W - 1);

    always_comb begin
        o_sat = 1'b0;
        if (r_neg[NW]) begin
            if (w_q > w_lim) begin
                o_sat = 1'b1;
                o_q   = {1'b1, {(W-1){1'b0}}};
            end else begin
                o_q   = W'(-w_q);
            end
        end else if (w_q >= w_lim) begin
            o_sat = 1'b1;
            o_q   = {1'b0, {(W-1){1'b1}}};
        end else begin
            o_q   = w_q[W-1:0];
        end
    end
endmodule
